// File: rtl/core/paper_tape_char_translator_defines.svh
// Assertion macros shared by the RTL that checks itself.
// The including module must provide clk and arst_n.
`ifndef PAPER_TAPE_CHAR_TRANSLATOR_DEFINES_SVH
`define PAPER_TAPE_CHAR_TRANSLATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PTC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: rtl/core/ptc_pkg.sv
package ptc_pkg;

	// Action codes of an input item.
	localparam logic [2:0] ACT_START    = 3'd0;
	localparam logic [2:0] ACT_STOP     = 3'd1;
	localparam logic [2:0] ACT_BYTE     = 3'd2;
	localparam logic [2:0] ACT_TAPE_END = 3'd3;
	localparam logic [2:0] ACT_STATUS   = 3'd4;

	// Parity mode codes.
	localparam logic [1:0] PAR_NONE  = 2'd0;
	localparam logic [1:0] PAR_EVEN  = 2'd1;
	localparam logic [1:0] PAR_REMAP = 2'd2;

	// Shift characters.
	localparam logic [5:0] SH_ALPHA = 6'o74;
	localparam logic [5:0] SH_BETA  = 6'o75;
	localparam logic [5:0] SH_DELTA = 6'o76;

	// Pound sign codes remapped in remap mode: IN becomes MID and MID becomes OUT.
	localparam logic [7:0] POUND_IN  = 8'o243;
	localparam logic [7:0] POUND_MID = 8'o044;
	localparam logic [7:0] POUND_OUT = 8'o174;

	localparam logic [6:0] BLANK_ONES = 7'o177;
	localparam logic [6:0] NEWLINE    = 7'o012;
	localparam logic [3:0] LO_LIMIT   = 4'o13;

	// Configuration register indexes and address width.
	localparam int PTC_ADDR_W = 5;
	localparam logic [2:0] REG_PARITY   = 3'd0;
	localparam logic [2:0] REG_BINARY   = 3'd1;
	localparam logic [2:0] REG_IGNBLANK = 3'd2;
	localparam logic [2:0] REG_STOPNL   = 3'd3;
	localparam logic [2:0] REG_KEEP     = 3'd4;

	localparam int PTC_QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] tape_byte;
		logic [1:0] room;
	} ptc_in_t;

	typedef struct packed {
		logic [5:0] out_char;
		logic       char_valid;
		logic       last;
		logic       busy_res;
		logic       stat_end;
		logic       stat_opat;
		logic       stat_error;
		logic       done_res;
	} ptc_out_t;

	typedef struct packed {
		logic [1:0] parity_mode;
		logic       binary_mode;
		logic       ignore_blank;
		logic       stop_on_newline;
		logic       keep_shift;
	} ptc_cfg_t;

	// Everything one item produces, as handed from front to back.
	typedef struct packed {
		logic [2:0][5:0] chars;
		logic [1:0]      cnt;
		logic            busy;
		logic            s_end;
		logic            s_opat;
		logic            s_err;
		logic            done;
	} ptc_entry_t;

endpackage

// File: rtl/core/ptc_front.sv
module ptc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  ptc_pkg::ptc_cfg_t   cfg,
	input  logic                item_valid,
	output logic                item_ready,
	input  ptc_pkg::ptc_in_t    item,
	output logic                push_valid,
	input  logic                push_ready,
	output ptc_pkg::ptc_entry_t push_entry
);
	import ptc_pkg::*;

	typedef struct packed {
		logic       alpha_mode;
		logic       running;
		logic       stop_pending;
		logic       end_flag;
		logic       opat_flag;
		logic       error_flag;
		logic [6:0] held;
	} ptc_state_t;

	ptc_state_t st_q;
	ptc_state_t ns;

	function automatic logic ends_rec(input logic [1:0] n, input logic [1:0] room);
		return (room != 2'd3) && (n >= room);
	endfunction

	assign item_ready = push_ready;
	assign push_valid = item_valid;

	always_comb begin
		logic [1:0]      cnt;
		logic [2:0][5:0] chars;
		logic            done;
		logic            halt;
		logic            send;
		logic            held_now;
		logic [7:0]      data;
		logic [6:0]      d7;
		logic [2:0]      grp;
		logic [3:0]      lo;
		logic [5:0]      ch;
		logic [5:0]      shift;

		ns       = st_q;
		cnt      = 2'd0;
		chars    = '0;
		done     = 1'b0;
		halt     = 1'b0;
		send     = 1'b0;
		held_now = 1'b0;
		data     = item.tape_byte;
		d7       = '0;
		grp      = '0;
		lo       = '0;
		ch       = '0;
		shift    = '0;

		unique case (item.action) inside
			ACT_START: begin
				if (st_q.running) begin
					ns.opat_flag = 1'b1;
					done = 1'b1;
				end else begin
					if (!cfg.keep_shift) ns.alpha_mode = 1'b1;
					ns.running      = 1'b1;
					ns.stop_pending = 1'b0;
					ns.end_flag     = 1'b0;
					ns.opat_flag    = 1'b0;
					ns.error_flag   = 1'b0;
				end
			end
			ACT_STOP: begin
				if (st_q.running) ns.stop_pending = 1'b1;
			end
			ACT_BYTE, ACT_TAPE_END: begin
				if (st_q.stop_pending) begin
					ns.running = 1'b0;
					ns.stop_pending = 1'b0;
					done = 1'b1;
					halt = 1'b1;
				end else if (!st_q.running) begin
					halt = 1'b1;
				end else if (st_q.held[6]) begin
					chars[0] = st_q.held[5:0];
					cnt = 2'd1;
					ns.held = '0;
					if (ends_rec(2'd1, item.room)) begin
						ns.running = 1'b0;
						ns.stop_pending = 1'b0;
						done = 1'b1;
						ns.end_flag = 1'b1;
						ns.opat_flag = 1'b0;
						ns.error_flag = 1'b0;
						halt = 1'b1;
					end
				end

				if (!halt && item.action == ACT_TAPE_END) begin
					ns.running = 1'b0;
					ns.stop_pending = 1'b0;
					done = 1'b1;
					ns.end_flag = 1'b1;
					ns.opat_flag = 1'b1;
					ns.error_flag = 1'b0;
				end else if (!halt) begin
					if (cfg.parity_mode == PAR_EVEN) begin
						if (^data) begin
							ns.end_flag = 1'b1;
							ns.error_flag = 1'b1;
							ns.opat_flag = 1'b0;
						end
						done = 1'b1;
					end else if (cfg.parity_mode == PAR_REMAP) begin
						if (data == POUND_IN) data = POUND_MID;
						else if (data == POUND_MID) data = POUND_OUT;
					end
					d7  = data[6:0];
					grp = d7[6:4];
					lo  = d7[3:0];

					if (cfg.ignore_blank && (d7 == 7'd0 || d7 == BLANK_ONES)) begin
						send = 1'b0;
					end else if (cfg.binary_mode) begin
						send = 1'b1;
						case (grp) inside
							3'd0, 3'd1: begin
								ns.end_flag = 1'b1;
								ns.running = 1'b0;
								ns.stop_pending = 1'b0;
								done = 1'b1;
								send = 1'b0;
							end
							3'd2:       ch = {2'b01, lo};
							3'd3:       ch = {2'b00, lo};
							3'd4, 3'd6: ch = {2'b10, lo};
							default:    ch = {2'b11, lo};
						endcase
					end else begin
						send = 1'b1;
						if (grp == 3'd0 || grp == 3'd1) begin
							if (cfg.stop_on_newline && d7 == NEWLINE) ns.end_flag = 1'b1;
							shift = SH_DELTA;
							ch = {2'b00, lo};
						end else if (grp == 3'd2) begin
							ch = {2'b01, lo};
						end else if (grp == 3'd3) begin
							ch = {2'b00, lo};
						end else if ((grp == 3'd6 || grp == 3'd7) && lo > LO_LIMIT) begin
							shift = SH_DELTA;
							ch = ((grp == 3'd6) ? 6'o70 : 6'o64) | {4'b0000, d7[1:0]};
						end else if (grp == 3'd4 || grp == 3'd6) begin
							if (!st_q.alpha_mode) shift = SH_ALPHA;
							ns.alpha_mode = 1'b1;
							ch = {1'b1, d7[4:0]};
						end else begin
							if (st_q.alpha_mode) shift = SH_BETA;
							ns.alpha_mode = 1'b0;
							ch = {1'b1, d7[4:0]};
						end
					end

					if (send) begin
						if (shift != 6'd0) begin
							chars[cnt] = shift;
							cnt = cnt + 2'd1;
							if (ends_rec(cnt, item.room) && ch != 6'd0) begin
								ns.end_flag = 1'b1;
								ns.running = 1'b0;
								ns.stop_pending = 1'b0;
								done = 1'b1;
								ns.held = {1'b1, ch};
								held_now = 1'b1;
							end
						end
						if (!held_now) begin
							chars[cnt] = ch;
							cnt = cnt + 2'd1;
							if (ends_rec(cnt, item.room)) begin
								ns.end_flag = 1'b1;
								ns.running = 1'b0;
								ns.stop_pending = 1'b0;
								done = 1'b1;
							end else if (ns.end_flag) begin
								ns.running = 1'b0;
								ns.stop_pending = 1'b0;
								done = 1'b1;
							end
						end
					end
				end
			end
			ACT_STATUS: begin
				ns.end_flag = 1'b0;
				ns.opat_flag = 1'b0;
				ns.error_flag = 1'b0;
			end
			default: begin
			end
		endcase

		push_entry.chars = chars;
		push_entry.cnt   = cnt;
		push_entry.done  = done;
		if (item.action == ACT_STATUS) begin
			push_entry.busy   = st_q.running;
			push_entry.s_end  = st_q.end_flag;
			push_entry.s_opat = st_q.opat_flag;
			push_entry.s_err  = st_q.error_flag;
		end else begin
			push_entry.busy   = ns.running;
			push_entry.s_end  = ns.end_flag;
			push_entry.s_opat = ns.opat_flag;
			push_entry.s_err  = ns.error_flag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{alpha_mode: 1'b1, running: 1'b0, stop_pending: 1'b0,
				end_flag: 1'b0, opat_flag: 1'b0, error_flag: 1'b0, held: 7'd0};
		end else if (item_valid && push_ready) begin
			st_q <= ns;
		end
	end

endmodule

// File: rtl/core/ptc_queue.sv
module ptc_queue #(
	parameter int DEPTH = ptc_pkg::PTC_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  ptc_pkg::ptc_entry_t push_entry,
	output logic                head_valid,
	input  logic                pop,
	output ptc_pkg::ptc_entry_t head
);
	import ptc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ptc_entry_t   mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) count_q <= count_q + CW'(1);
			else if (do_pop && !do_push) count_q <= count_q - CW'(1);
		end
	end

endmodule

// File: rtl/core/ptc_back.sv
module ptc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  ptc_pkg::ptc_entry_t head,
	output logic                pop,
	output logic                res_valid,
	input  logic                res_ready,
	output ptc_pkg::ptc_out_t   res
);
	import ptc_pkg::*;

	// Index of the result of the head entry now on the output.
	logic [1:0] k_q;
	logic       is_last;

	assign is_last   = (head.cnt == 2'd0) || ((k_q + 2'd1) == head.cnt);
	assign res_valid = head_valid;
	assign pop       = head_valid && res_ready && is_last;

	always_comb begin
		res.out_char   = (head.cnt == 2'd0) ? 6'd0 : head.chars[k_q];
		res.char_valid = (head.cnt != 2'd0);
		res.last       = is_last;
		res.busy_res   = head.busy;
		res.stat_end   = head.s_end;
		res.stat_opat  = head.s_opat;
		res.stat_error = head.s_err;
		res.done_res   = is_last && head.done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= 2'd0;
		end else if (head_valid && res_ready) begin
			k_q <= is_last ? 2'd0 : k_q + 2'd1;
		end
	end

endmodule

// File: rtl/core/paper_tape_char_translator.sv
// Paper tape reader controller. Each input item is a start, stop, tape byte, tape end or
// status read event; each causes one to three result items, one per channel character
// sent, or a single item with char_valid low when nothing is sent. The last result of an
// item has last set and carries the done pulse; all results of an item carry the same
// status. The front accepts one item per cycle while the queue has room and works out all
// its results and the new reader state at once; a two-entry queue then hands them to the
// back, which delivers one result per cycle while res_ready is high. An item therefore holds
// the output until all of its results are taken, and that output sequencer sets the sustained
// rate. Configuration registers sit on an APB port at byte addresses 0, 4, 8, 12 and 16
// (parity mode, binary mode, ignore blank, stop on newline, keep shift); they take effect on
// the next item and are to be written only while the block is idle, which it does not enforce.
`include "paper_tape_char_translator_defines.svh"

module paper_tape_char_translator #(
	parameter int QUEUE_DEPTH = ptc_pkg::PTC_QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  ptc_pkg::ptc_in_t               item,
	output logic                           res_valid,
	input  logic                           res_ready,
	output ptc_pkg::ptc_out_t              res,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ptc_pkg::PTC_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import ptc_pkg::*;

	ptc_cfg_t   cfg_q;
	ptc_entry_t push_entry;
	ptc_entry_t head;
	logic       push_valid;
	logic       push_ready;
	logic       head_valid;
	logic       pop;
	logic [2:0] reg_idx;

	// The register index is the word address; the low two address bits are ignored.
	assign reg_idx = paddr[4:2];
	assign pready  = 1'b1;

	// Configuration registers. Writes to unused addresses are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{parity_mode: PAR_NONE, binary_mode: 1'b0, ignore_blank: 1'b1,
				stop_on_newline: 1'b0, keep_shift: 1'b0};
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_PARITY:   cfg_q.parity_mode     <= pwdata[1:0];
				REG_BINARY:   cfg_q.binary_mode     <= pwdata[0];
				REG_IGNBLANK: cfg_q.ignore_blank    <= pwdata[0];
				REG_STOPNL:   cfg_q.stop_on_newline <= pwdata[0];
				REG_KEEP:     cfg_q.keep_shift      <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// Read back returns the stored value zero-extended; unused addresses read zero.
	always_comb begin
		unique case (reg_idx)
			REG_PARITY:   prdata = {30'd0, cfg_q.parity_mode};
			REG_BINARY:   prdata = {31'd0, cfg_q.binary_mode};
			REG_IGNBLANK: prdata = {31'd0, cfg_q.ignore_blank};
			REG_STOPNL:   prdata = {31'd0, cfg_q.stop_on_newline};
			REG_KEEP:     prdata = {31'd0, cfg_q.keep_shift};
			default:      prdata = 32'd0;
		endcase
	end

	// The front decodes each item, updates the reader state and builds its result entry.
	ptc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	// The queue decouples the front from a stalled channel.
	ptc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.head_valid (head_valid),
		.pop        (pop),
		.head       (head)
	);

	// The back walks the characters of the head entry, one result per cycle while res_ready is high.
	ptc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// A result without a character is always the only, and so the last, one of its item.
	`PTC_ASSERT_SAME(a_nochar_last, res_valid && !res.char_valid, res.last)
	// The done pulse rides only on the last result of an item.
	`PTC_ASSERT_SAME(a_done_on_last, res_valid && !res.last, !res.done_res)
	// After an accepted item the queue holds an entry, so the output is valid in the next cycle.
	`PTC_ASSERT_NEXT(a_push_shows, item_valid && item_ready, res_valid)

endmodule

// File: tb/paper_tape_char_translator_tb.sv
module paper_tape_char_translator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ptc_pkg::*;

	// Codes the package leaves unnamed: an action value the reader ignores and
	// the spare parity mode, which behaves like no parity at all.
	localparam logic [2:0] ACT_UNUSED = 3'd7;
	localparam logic [1:0] PAR_SPARE  = 2'd3;

	localparam int unsigned IDLE_PCT     = 26;
	localparam int unsigned PHASE_ITEMS  = 42;
	localparam int unsigned CALM_FROM    = 120;
	localparam int unsigned CALM_TO      = 180;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned STALL_LIMIT  = 1000;

	typedef enum logic [1:0] {
		ROW_SETTING,
		ROW_PREDICTED,
		ROW_FIXED
	} row_kind_e;

	// One line of the directed table: either a register setting to apply while
	// the reader is idle, or an input item whose result is predicted or typed in.
	typedef struct {
		row_kind_e kind;
		ptc_cfg_t  setting;
		ptc_in_t   stim;
		ptc_out_t  want;
	} tape_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_ready;
	ptc_in_t               item;
	logic                  res_valid;
	logic                  res_ready;
	ptc_out_t              res;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PTC_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	paper_tape_char_translator DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	// 12 ns clock period.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Our own copy of the reader: the register settings and every state bit.
	ptc_cfg_t   cfg;
	logic       alpha_mode;
	logic       running;
	logic       stop_pending;
	logic       end_flag;
	logic       opat_flag;
	logic       error_flag;
	logic [6:0] held_char;

	// Per-item scratch: the characters sent to the channel so far, the room
	// the channel has left, and whether this item pulses done.
	logic [5:0]  sent_chars [3];
	int unsigned sent_cnt;
	logic [1:0]  step_room;
	logic        step_done;

	// Channel characters (and bare status items) the reader still owes us, oldest first.
	ptc_out_t channel_chars[$];

	tape_row_t   directed_rows[$];
	int unsigned mismatch_count;
	int unsigned random_done;
	int unsigned stall_cycles;
	bit          calm;

	// Puts one character on the channel. It returns 1 when that character
	// fills the record; room 3 means the channel never fills within one item,
	// and room 0 means every character fills it.
	function automatic bit send_char(logic [5:0] c);
		if (sent_cnt < 3) begin
			sent_chars[sent_cnt] = c;
			sent_cnt++;
		end
		return step_room != 2'd3 && sent_cnt >= step_room;
	endfunction

	function automatic void end_read();
		running = 1'b0;
		stop_pending = 1'b0;
		step_done = 1'b1;
	endfunction

	// Common front of a tape byte and a tape end. A pending stop ends the
	// read, an idle reader ignores the item, and a character held back by an
	// earlier end of record goes out first. Returns 1 when the tape is not
	// looked at.
	function automatic bit head_stops();
		logic [5:0] c;
		if (stop_pending) begin
			end_read();
			return 1'b1;
		end
		if (!running)
			return 1'b1;
		if (held_char[6]) begin
			c = held_char[5:0];
			held_char = '0;
			if (send_char(c)) begin
				end_read();
				end_flag = 1'b1;
				opat_flag = 1'b0;
				error_flag = 1'b0;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Parity check or pound remap, blank skip, then translation of one byte.
	function automatic void take_byte(logic [7:0] raw);
		logic [7:0] d8;
		logic [6:0] d;
		logic [2:0] grp;
		logic [3:0] lo;
		logic [5:0] ch;
		logic [5:0] sh;
		d8 = raw;
		ch = '0;
		sh = '0;
		if (cfg.parity_mode == PAR_EVEN) begin
			// An odd byte flags the error but is still translated; the read
			// then stops once the byte is done, unless the byte is a skipped blank.
			if (^raw) begin
				end_flag = 1'b1;
				error_flag = 1'b1;
				opat_flag = 1'b0;
			end
			step_done = 1'b1;
		end else if (cfg.parity_mode == PAR_REMAP) begin
			if (raw == POUND_IN)
				d8 = POUND_MID;
			else if (raw == POUND_MID)
				d8 = POUND_OUT;
		end
		d = d8[6:0];
		if ((d == '0 || d == BLANK_ONES) && cfg.ignore_blank)
			return;

		grp = d[6:4];
		lo = d[3:0];
		if (cfg.binary_mode) begin
			// Control codes end the read without sending anything.
			if (grp <= 3'd1) begin
				end_flag = 1'b1;
				end_read();
				return;
			end
			case (grp)
				3'd2: ch = {2'b01, lo};
				3'd3: ch = {2'b00, lo};
				3'd4, 3'd6: ch = {2'b10, lo};
				default: ch = {2'b11, lo};
			endcase
		end else begin
			if (grp <= 3'd1) begin
				if (cfg.stop_on_newline && d == NEWLINE)
					end_flag = 1'b1;
				sh = SH_DELTA;
				ch = {2'b00, lo};
			end else if (grp == 3'd2) begin
				ch = {2'b01, lo};
			end else if (grp == 3'd3) begin
				ch = {2'b00, lo};
			end else if ((grp == 3'd6 || grp == 3'd7) && lo > LO_LIMIT) begin
				sh = SH_DELTA;
				ch = (grp == 3'd6 ? 6'o70 : 6'o64) | {4'b0000, d[1:0]};
			end else if (grp == 3'd4 || grp == 3'd6) begin
				if (!alpha_mode)
					sh = SH_ALPHA;
				alpha_mode = 1'b1;
				ch = {1'b1, d[4:0]};
			end else begin
				if (alpha_mode)
					sh = SH_BETA;
				alpha_mode = 1'b0;
				ch = {1'b1, d[4:0]};
			end
		end

		// A shift code that fills the record holds back a nonzero character
		// for the next read; a zero character still goes out.
		if (sh != '0) begin
			if (send_char(sh) && ch != '0) begin
				end_flag = 1'b1;
				end_read();
				held_char = {1'b1, ch};
				return;
			end
		end
		if (send_char(ch)) begin
			end_flag = 1'b1;
			end_read();
			return;
		end
		if (end_flag)
			end_read();
	endfunction

	// Steps our copy of the reader by one input item and queues what the
	// channel should see: one entry per character, or one bare entry.
	function automatic void translate_item(ptc_in_t it);
		ptc_out_t r;
		logic     sb, se, so, sr;
		int       n;
		int       k;
		sent_cnt = 0;
		step_done = 1'b0;
		step_room = it.room;
		sb = 1'b0;
		se = 1'b0;
		so = 1'b0;
		sr = 1'b0;
		case (it.action)
			ACT_START: begin
				if (running) begin
					opat_flag = 1'b1;
					step_done = 1'b1;
				end else begin
					if (!cfg.keep_shift)
						alpha_mode = 1'b1;
					running = 1'b1;
					stop_pending = 1'b0;
					end_flag = 1'b0;
					opat_flag = 1'b0;
					error_flag = 1'b0;
				end
			end
			ACT_STOP: begin
				if (running)
					stop_pending = 1'b1;
			end
			ACT_BYTE: begin
				if (!head_stops())
					take_byte(it.tape_byte);
			end
			ACT_TAPE_END: begin
				if (!head_stops()) begin
					end_read();
					end_flag = 1'b1;
					opat_flag = 1'b1;
					error_flag = 1'b0;
				end
			end
			ACT_STATUS: begin
				// The status shown is the one from before the clear.
				sb = running;
				se = end_flag;
				so = opat_flag;
				sr = error_flag;
				end_flag = 1'b0;
				opat_flag = 1'b0;
				error_flag = 1'b0;
			end
			default: ;
		endcase
		if (it.action != ACT_STATUS) begin
			sb = running;
			se = end_flag;
			so = opat_flag;
			sr = error_flag;
		end

		n = (sent_cnt == 0) ? 1 : sent_cnt;
		for (k = 0; k < n; k++) begin
			r = '0;
			r.out_char = (sent_cnt == 0) ? 6'd0 : sent_chars[k];
			r.char_valid = (sent_cnt != 0);
			r.last = (k == n - 1);
			r.busy_res = sb;
			r.stat_end = se;
			r.stat_opat = so;
			r.stat_error = sr;
			r.done_res = (k == n - 1) ? step_done : 1'b0;
			channel_chars.push_back(r);
		end
	endfunction

	function automatic ptc_cfg_t reader_setting(logic [1:0] par, logic bin, logic ign,
		logic nl, logic keep);
		ptc_cfg_t s;
		s.parity_mode = par;
		s.binary_mode = bin;
		s.ignore_blank = ign;
		s.stop_on_newline = nl;
		s.keep_shift = keep;
		return s;
	endfunction

	// A result with no character: only the status, last set.
	function automatic ptc_out_t bare_result(logic busy, logic s_end, logic s_opat,
		logic s_err, logic done);
		ptc_out_t r;
		r = '0;
		r.last = 1'b1;
		r.busy_res = busy;
		r.stat_end = s_end;
		r.stat_opat = s_opat;
		r.stat_error = s_err;
		r.done_res = done;
		return r;
	endfunction

	function automatic void add_setting(ptc_cfg_t s);
		tape_row_t row;
		row.kind = ROW_SETTING;
		row.setting = s;
		row.stim = '0;
		row.want = '0;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_stim(logic [2:0] action, logic [7:0] tape, logic [1:0] room);
		tape_row_t row;
		row.kind = ROW_PREDICTED;
		row.setting = '0;
		row.stim.action = action;
		row.stim.tape_byte = tape;
		row.stim.room = room;
		row.want = '0;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_fixed(logic [2:0] action, logic [7:0] tape, logic [1:0] room,
		ptc_out_t want);
		tape_row_t row;
		row.kind = ROW_FIXED;
		row.setting = '0;
		row.stim.action = action;
		row.stim.tape_byte = tape;
		row.stim.room = room;
		row.want = want;
		directed_rows.push_back(row);
	endfunction

	task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
		$display("%0t: %s differs, got %h, expected %h", $realtime, field, got, want);
		mismatch_count++;
	endtask

	task automatic check_result(ptc_out_t got, ptc_out_t want);
		if (got.out_char !== want.out_char)
			report_mismatch("out_char", got.out_char, want.out_char);
		if (got.char_valid !== want.char_valid)
			report_mismatch("char_valid", got.char_valid, want.char_valid);
		if (got.last !== want.last)
			report_mismatch("last", got.last, want.last);
		if (got.busy_res !== want.busy_res)
			report_mismatch("busy_res", got.busy_res, want.busy_res);
		if (got.stat_end !== want.stat_end)
			report_mismatch("stat_end", got.stat_end, want.stat_end);
		if (got.stat_opat !== want.stat_opat)
			report_mismatch("stat_opat", got.stat_opat, want.stat_opat);
		if (got.stat_error !== want.stat_error)
			report_mismatch("stat_error", got.stat_error, want.stat_error);
		if (got.done_res !== want.done_res)
			report_mismatch("done_res", got.done_res, want.done_res);
	endtask

	// One APB write: a setup cycle, then an access cycle that completes at the
	// rising edge where pready is high. Called at a falling edge.
	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			REG_PARITY:   cfg.parity_mode = value[1:0];
			REG_BINARY:   cfg.binary_mode = value[0];
			REG_IGNBLANK: cfg.ignore_blank = value[0];
			REG_STOPNL:   cfg.stop_on_newline = value[0];
			REG_KEEP:     cfg.keep_shift = value[0];
			default: ;
		endcase
	endtask

	// Registers change only on an idle reader: the item port is parked and
	// every owed result has come back before the first write. Every item
	// produces at least one result, so an empty queue means the reader is idle.
	task automatic apply_setting(ptc_cfg_t s);
		item_valid = 1'b0;
		while (channel_chars.size() != 0)
			@(negedge clk);
		write_reg(REG_PARITY, 32'(s.parity_mode));
		write_reg(REG_BINARY, 32'(s.binary_mode));
		write_reg(REG_IGNBLANK, 32'(s.ignore_blank));
		write_reg(REG_STOPNL, 32'(s.stop_on_newline));
		write_reg(REG_KEEP, 32'(s.keep_shift));
	endtask

	// Offers one item, starting and ending at a falling edge. The item is
	// stepped through our model as soon as it is offered, so its results are
	// queued before the reader can return them. On return valid is still high;
	// the caller either offers the next item or parks the port in that step.
	task automatic send_item(ptc_in_t it, bit typed, ptc_out_t want);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item = it;
		item_valid = 1'b1;
		translate_item(it);
		// A typed-in row always yields a single result; it stands in for the
		// one the model just queued.
		if (typed)
			channel_chars[channel_chars.size() - 1] = want;
		do
			@(posedge clk);
		while (!item_ready);
		@(negedge clk);
	endtask

	// Random reads under one register setting. Most items follow a running
	// read (start, then mostly tape bytes), with stops, tape ends, status
	// reads, restarts and unused actions mixed in. Items the reader merely
	// ignores do not count toward the quota.
	task automatic run_tape_phase(ptc_cfg_t s, int unsigned quota);
		ptc_in_t     it;
		int unsigned counted;
		int unsigned roll;
		bit          skipped;
		apply_setting(s);
		counted = 0;
		while (counted < quota) begin
			roll = $urandom_range(99);
			if (!running && $urandom_range(9) < 7)
				it.action = ACT_START;
			else if (roll < 78)
				it.action = ACT_BYTE;
			else if (roll < 83)
				it.action = ACT_STOP;
			else if (roll < 87)
				it.action = ACT_TAPE_END;
			else if (roll < 93)
				it.action = ACT_STATUS;
			else if (roll < 96)
				it.action = ACT_START;
			else
				it.action = 3'($urandom_range(5, 7));

			// In parity mode most bytes are made even so reads get past the
			// first byte; in remap mode the two pound codes show up often.
			it.tape_byte = 8'($urandom_range(255));
			if (s.parity_mode == PAR_EVEN && $urandom_range(3) != 0)
				it.tape_byte[7] = ^it.tape_byte[6:0];
			else if (s.parity_mode == PAR_REMAP && $urandom_range(7) == 0)
				it.tape_byte = $urandom_range(1) ? POUND_IN : POUND_MID;
			it.room = ($urandom_range(9) < 6) ? 2'd3 : 2'($urandom_range(2));

			skipped = it.action > ACT_STATUS || (!running && (it.action == ACT_STOP
				|| it.action == ACT_BYTE || it.action == ACT_TAPE_END));
			calm = random_done >= CALM_FROM && random_done < CALM_TO;
			send_item(it, 1'b0, '0);
			if (!skipped) begin
				counted++;
				random_done++;
			end
		end
	endtask

	// The channel side stalls at random too, except during the calm stretch.
	always @(negedge clk) begin
		res_ready = calm || ($urandom_range(99) >= IDLE_PCT);
	end

	// Every character the reader hands over is matched against the oldest
	// one we still owe.
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (channel_chars.size() == 0)
				report_mismatch("unexpected result", 16'(res), '0);
			else
				check_result(res, channel_chars.pop_front());
		end
	end

	// Watchdog: too many cycles in a row with no item moving on either side
	// means the reader is stuck or has dropped something.
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (res_valid && res_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $realtime, stall_cycles);
			$display("paper_tape_char_translator: mismatch");
			$finish;
		end
	end

	initial begin
		tape_row_t row;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		res_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		calm = 1'b0;
		mismatch_count = 0;
		random_done = 0;
		stall_cycles = 0;

		// Our copy of the reader starts out as the hardware does after reset.
		cfg = reader_setting(PAR_NONE, 1'b0, 1'b1, 1'b0, 1'b0);
		alpha_mode = 1'b1;
		running = 1'b0;
		stop_pending = 1'b0;
		end_flag = 1'b0;
		opat_flag = 1'b0;
		error_flag = 1'b0;
		held_char = '0;

		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: status after reset, items the idle reader ignores,
		// start and a second start while running.
		add_fixed(ACT_STATUS, 8'h00, 2'd3, bare_result(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
		add_fixed(ACT_BYTE, 8'hff, 2'd0, bare_result(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
		add_fixed(ACT_UNUSED, 8'h00, 2'd3, bare_result(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
		add_fixed(ACT_START, 8'h00, 2'd3, bare_result(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
		add_fixed(ACT_START, 8'h00, 2'd3, bare_result(1'b1, 1'b0, 1'b1, 1'b0, 1'b1));
		// Blank skip, beta shift, newline under delta, delta special, then an
		// alpha shift that fills the record and holds its character back.
		add_stim(ACT_BYTE, 8'h00, 2'd3);
		add_stim(ACT_BYTE, 8'h51, 2'd3);
		add_stim(ACT_BYTE, 8'h0a, 2'd3);
		add_stim(ACT_BYTE, 8'h7c, 2'd3);
		add_stim(ACT_BYTE, 8'h61, 2'd1);
		// Restart: the held character goes out ahead of the next one.
		add_stim(ACT_START, 8'h00, 2'd3);
		add_stim(ACT_BYTE, 8'h30, 2'd3);
		// Stop makes the next byte end the read and throws that byte away.
		add_stim(ACT_STOP, 8'h00, 2'd3);
		add_stim(ACT_BYTE, 8'h41, 2'd3);
		add_fixed(ACT_START, 8'h00, 2'd3, bare_result(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
		add_fixed(ACT_TAPE_END, 8'h00, 2'd3, bare_result(1'b0, 1'b1, 1'b1, 1'b0, 1'b1));
		add_fixed(ACT_STATUS, 8'h00, 2'd3, bare_result(1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
		// Even parity in binary mode: a good byte, then an odd control byte.
		add_setting(reader_setting(PAR_EVEN, 1'b1, 1'b0, 1'b1, 1'b1));
		add_stim(ACT_START, 8'h00, 2'd3);
		add_stim(ACT_BYTE, 8'h41, 2'd3);
		add_stim(ACT_BYTE, 8'h01, 2'd3);
		// Pound remap, a delta pair that fills the record, a zero character
		// after a filling shift code, and the stop on newline.
		add_setting(reader_setting(PAR_REMAP, 1'b0, 1'b0, 1'b1, 1'b0));
		add_stim(ACT_START, 8'h00, 2'd3);
		add_stim(ACT_BYTE, 8'ha3, 2'd3);
		add_stim(ACT_BYTE, 8'h24, 2'd2);
		add_stim(ACT_START, 8'h00, 2'd3);
		add_stim(ACT_BYTE, 8'h00, 2'd1);
		add_stim(ACT_START, 8'h00, 2'd3);
		add_stim(ACT_BYTE, 8'h0a, 2'd3);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			case (row.kind)
				ROW_SETTING: apply_setting(row.setting);
				ROW_FIXED:   send_item(row.stim, 1'b1, row.want);
				default:     send_item(row.stim, 1'b0, '0);
			endcase
		end

		// Random reads: the two extreme settings first, then mixed ones.
		run_tape_phase(reader_setting(PAR_NONE, 1'b0, 1'b0, 1'b0, 1'b0), PHASE_ITEMS);
		run_tape_phase(reader_setting(PAR_SPARE, 1'b1, 1'b1, 1'b1, 1'b1), PHASE_ITEMS);
		run_tape_phase(reader_setting(PAR_EVEN, 1'b0, 1'b1, 1'b0, 1'b1), PHASE_ITEMS);
		run_tape_phase(reader_setting(PAR_REMAP, 1'b0, 1'b1, 1'b1, 1'b0), PHASE_ITEMS);
		repeat (3)
			run_tape_phase(reader_setting(2'($urandom_range(3)), 1'($urandom_range(1)),
				1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1))),
				PHASE_ITEMS);

		// Park the item port, collect what is still owed, then keep the reader
		// running a while longer to show any stray result.
		item_valid = 1'b0;
		calm = 1'b0;
		while (channel_chars.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);

		if (mismatch_count == 0)
			$display("paper_tape_char_translator: match");
		else
			$display("paper_tape_char_translator: mismatch");
		$finish;
	end

endmodule

// File: paper_tape_char_translator.f
+incdir+rtl/core
rtl/core/ptc_pkg.sv
rtl/core/ptc_front.sv
rtl/core/ptc_queue.sv
rtl/core/ptc_back.sv
rtl/core/paper_tape_char_translator.sv
tb/paper_tape_char_translator_tb.sv
